// ===== rtl/core/bir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_pkg - shared definitions for the boot image receiver
// Opcodes, status codes, register indexes, field widths and the CRC-16
// byte update.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int unsigned DefMaxImageBytes = 65536;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 16;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned RegW    = 16;
  localparam int unsigned CountW  = 18;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // opcodes
  typedef enum logic [OpW-1:0] {
    OP_START  = 2'd0,
    OP_TICK   = 2'd1,
    OP_BYTE   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // result status codes
  localparam logic [StatusW-1:0] ST_IGNORED  = 3'd0;
  localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd1;
  localparam logic [StatusW-1:0] ST_EXCESS   = 3'd2;
  localparam logic [StatusW-1:0] ST_CRC_OK   = 3'd3;
  localparam logic [StatusW-1:0] ST_CRC_FAIL = 3'd4;
  localparam logic [StatusW-1:0] ST_TOO_MUCH = 3'd5;
  localparam logic [StatusW-1:0] ST_SHORT    = 3'd6;

  // register indexes
  localparam logic [IdxW-1:0] REG_PAYLOAD = 2'd0;
  localparam logic [IdxW-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [IdxW-1:0] REG_POLY    = 2'd2;

  localparam logic [RegW-1:0]   RstPayload = 16'd0;
  localparam logic [RegW-1:0]   RstTimeout = 16'd1000;
  localparam logic [RegW-1:0]   RstPoly    = 16'h1021;
  localparam logic [RegW-1:0]   IdleTop    = 16'hFFFF;
  localparam logic [CountW-1:0] CountTop   = 18'h3FFFF;

  typedef struct packed {
    logic [CrcW-1:0]    computed_crc;
    logic               image_good;
    logic [ByteW-1:0]   store_data;
    logic [AddrW-1:0]   store_address;
    logic               store_valid;
    logic [StatusW-1:0] status;
  } res_t;

  // MSB-first CRC-16 over one byte, table entry formed on the fly
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0]  crc,
                                                 input logic [ByteW-1:0] data,
                                                 input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] r;
    r = {crc[15:8] ^ data, 8'h00};
    for (int i = 0; i < ByteW; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
    end
    return {crc[7:0], 8'h00} ^ r;
  endfunction

endpackage

// ===== rtl/core/boot_image_receiver_crc16_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boot_image_receiver_crc16_top - CRC-16 checked download image receiver
// Byte stream receiver with buffer write-out, idle timeout and CRC verdict.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per item. in_tuser carries the opcode (start, idle
//           tick, byte), in_tdata the received byte.
//   out_* : exactly one result transfer per input item, in order. out_tuser
//           carries the status, out_tdata the buffer write and CRC status.
//   cfg_* : register writes, taken at once; write only while idle.
// Each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: 1 item per cycle while in_tready is high; the CRC byte update, counters and compares
//   all sit between the state registers and the result register.
// Results leave through an output register backed by one skid entry, so
//   the input side keeps taking items while a result waits. If the receiver
//   stalls for more than one item, in_tready falls until the skid drains.
// Reset (synchronous, rst_n low): reception disarmed, counters and CRCs
//   cleared, registers back to their defaults, output empty.
// ----------------------------------------------------------------------------
module boot_image_receiver_crc16_top #(
  parameter int unsigned MAX_IMAGE_BYTES = bir_pkg::DefMaxImageBytes
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bir_pkg::InDataW-1:0]   in_tdata,   // [7:0] byte_value
  input  logic [bir_pkg::OpW-1:0]       in_tuser,   // [1:0] opcode
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] store_valid, [16:1] store_address, [24:17] store_data,
  // [25] image_good, [41:26] computed_crc, [47:42] zero
  output logic [bir_pkg::OutDataW-1:0]  out_tdata,
  output logic [bir_pkg::StatusW-1:0]   out_tuser,  // [2:0] status
  // configuration
  input  logic                          cfg_we,
  input  logic [bir_pkg::IdxW-1:0]      cfg_index,
  input  logic [bir_pkg::RegW-1:0]      cfg_wdata
);
  import bir_pkg::*;

  localparam logic [CountW-1:0] MaxBytes = CountW'(MAX_IMAGE_BYTES);

  // configuration registers
  logic [RegW-1:0] payload_r, timeout_r, poly_r;

  // receiver state
  logic              receiving_r, receiving_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [RegW-1:0]   idle_r, idle_nxt;
  logic [CrcW-1:0]   crc_r, crc_nxt;
  logic [CrcW-1:0]   trailer_r, trailer_nxt;
  logic              passed_r, passed_nxt;

  // output register and skid entry
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res;

  logic              accept;
  logic [CountW-1:0] expected;
  logic              fits;
  op_t               op;
  logic [ByteW-1:0]  din;

  assign in_tready = ~skid_valid_r;
  assign accept    = in_tvalid & in_tready;
  assign op        = op_t'(in_tuser);
  assign din       = in_tdata[ByteW-1:0];
  assign expected  = CountW'(payload_r) + CountW'(2);
  assign fits      = (expected <= MaxBytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_r <= RstPayload;
      timeout_r <= RstTimeout;
      poly_r    <= RstPoly;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAYLOAD: payload_r <= cfg_wdata;
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        REG_POLY:    poly_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    receiving_nxt = receiving_r;
    count_nxt     = count_r;
    idle_nxt      = idle_r;
    crc_nxt       = crc_r;
    trailer_nxt   = trailer_r;
    passed_nxt    = passed_r;
    res           = '0;
    res.status    = ST_IGNORED;

    unique case (op)
      OP_START: begin
        receiving_nxt = 1'b1;
        count_nxt     = '0;
        idle_nxt      = '0;
        crc_nxt       = '0;
        trailer_nxt   = '0;
        passed_nxt    = 1'b0;
        res.status    = ST_ACCEPTED;
      end
      OP_TICK: begin
        if (receiving_r) begin
          if (idle_r != IdleTop) idle_nxt = idle_r + RegW'(1);
          if (idle_nxt >= timeout_r) begin
            receiving_nxt = 1'b0;
            if (count_r == expected && fits) begin
              passed_nxt = (trailer_r == crc_r);
              res.status = passed_nxt ? ST_CRC_OK : ST_CRC_FAIL;
            end else if (count_r >= expected) begin
              res.status = ST_TOO_MUCH;
            end else begin
              res.status = ST_SHORT;
            end
          end else begin
            res.status = ST_ACCEPTED;
          end
        end
      end
      OP_BYTE: begin
        if (receiving_r) begin
          idle_nxt = '0;
          if (count_r >= expected || count_r >= MaxBytes) begin
            res.status = ST_EXCESS;
          end else begin
            res.status        = ST_ACCEPTED;
            res.store_valid   = 1'b1;
            res.store_address = count_r[AddrW-1:0];
            res.store_data    = din;
            // payload feeds the CRC, the last two bytes form the trailer
            if (count_r < CountW'(payload_r)) crc_nxt = crc16_byte(crc_r, din, poly_r);
            else trailer_nxt = {trailer_r[7:0], din};
          end
          if (count_r != CountTop) count_nxt = count_r + CountW'(1);
        end
      end
      default: ;
    endcase

    res.image_good   = passed_nxt;
    res.computed_crc = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      count_r     <= '0;
      idle_r      <= '0;
      crc_r       <= '0;
      trailer_r   <= '0;
      passed_r    <= 1'b0;
    end else if (accept) begin
      receiving_r <= receiving_nxt;
      count_r     <= count_nxt;
      idle_r      <= idle_nxt;
      crc_r       <= crc_nxt;
      trailer_r   <= trailer_nxt;
      passed_r    <= passed_nxt;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (accept)  out_r <= res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {6'b0, out_r.computed_crc, out_r.image_good, out_r.store_data,
                       out_r.store_address, out_r.store_valid};

endmodule

// ===== rtl/core/bir_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bir_sva_checker - port-level checks for the boot image receiver
// Result stream consistency and output hold under back-pressure.
// ----------------------------------------------------------------------------
module bir_sva_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bir_pkg::OutDataW-1:0]  out_tdata,
  input logic [bir_pkg::StatusW-1:0]   out_tuser
);
  import bir_pkg::*;

  // a buffer write only comes with an accepted byte
  a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tuser == ST_ACCEPTED)
    else $error("store without accepted status");

  // no write means address and data are zero
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[24:1] == '0)
    else $error("store fields set without a store");

  // a passing verdict raises image_good; a failing one clears it
  a_verdict_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_CRC_OK || out_tuser == ST_CRC_FAIL)
    |-> out_tdata[25] == (out_tuser == ST_CRC_OK))
    else $error("image_good disagrees with verdict");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind boot_image_receiver_crc16_top bir_sva_checker u_bir_sva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
